[hw/rtl/irc_pkg.sv]
`default_nettype none

package irc_pkg;

  localparam int unsigned CODE_BITS_DEF = 16;
  localparam int unsigned GAP_W         = 16;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned KEY_W         = 4;
  localparam int unsigned OUT_CODE_W    = 16;
  localparam int unsigned NUM_DIGITS    = 10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_MIN   = 3'd0,
    CFG_SYNC_MAX   = 3'd1,
    CFG_ONE_MIN    = 3'd2,
    CFG_ONE_MAX    = 3'd3,
    CFG_ZERO_FLOOR = 3'd4,
    CFG_FIVE_CODE  = 3'd5
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] SYNC_MIN_RST   = 16'd2800;
  localparam logic [CFG_W-1:0] SYNC_MAX_RST   = 16'd15000;
  localparam logic [CFG_W-1:0] ONE_MIN_RST    = 16'd1500;
  localparam logic [CFG_W-1:0] ONE_MAX_RST    = 16'd2300;
  localparam logic [CFG_W-1:0] ZERO_FLOOR_RST = 16'd800;
  localparam logic [CFG_W-1:0] FIVE_CODE_RST  = 16'd43168;

  localparam logic [KEY_W-1:0] KEY_DIGIT_FIVE = 4'd5;
  localparam logic [KEY_W-1:0] KEY_DELETE     = 4'd10;
  localparam logic [KEY_W-1:0] KEY_SEND       = 4'd11;
  localparam logic [KEY_W-1:0] KEY_NONE       = 4'd12;

  // digit five is programmable, its slot here is unused
  localparam logic [15:0] DIGIT_CODES [NUM_DIGITS] = '{
    16'hA800, 16'hA880, 16'hA840, 16'hA8C0, 16'hA820,
    16'h0000, 16'hA860, 16'hA8E0, 16'hA810, 16'hA890
  };
  localparam logic [15:0] CODE_DELETE = 16'hA830;
  localparam logic [15:0] CODE_SEND   = 16'h2848;

  // first match wins: digits 0-9, then send, then delete
  function automatic logic [KEY_W-1:0] key_for(input logic [31:0] word,
                                              input logic [CFG_W-1:0] five);
    logic [KEY_W-1:0] key;
    logic [31:0]      code;
    key = KEY_NONE;
    if (word == 32'(CODE_DELETE)) key = KEY_DELETE;
    if (word == 32'(CODE_SEND)) key = KEY_SEND;
    for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
      code = (KEY_W'(k) == KEY_DIGIT_FIVE) ? 32'(five) : 32'(DIGIT_CODES[k]);
      if (word == code) key = KEY_W'(k);
    end
    return key;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ir_remote_code_decoder_top.sv]
`default_nettype none

// Pulse-distance decoder for infrared remotes. Each slave transfer carries the
// time in microseconds between successive falling edges of the receiver. A gap in the
// sync window arms the decoder; while armed, gaps in the one and zero windows
// shift in bits, first bit most significant. After CODE_BITS bits one master
// transfer carries the low 16 bits of the code and a key index (0-9 digits,
// 10 delete, 11 send, 12 unrecognized); the decoder then clears and disarms.
// One gap is taken every clock cycle unless the input side stalls: the gap is
// registered, then classified, shifted and matched against the key table in a
// single stage that writes the result register, from which the result is
// offered. The input side keeps accepting while a result waits for tready, and
// stalls only when a completing gap finds the result register still full.
// Window bounds and the code for digit five are written on the cfg port; the
// user must write them only while idle, as the block does not enforce it.
module ir_remote_code_decoder_top
  import irc_pkg::*;
#(
  parameter int unsigned CODE_BITS = irc_pkg::CODE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // slave stream: [15:0] gap_us
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [irc_pkg::GAP_W-1:0]     s_axis_tdata,
  // master stream: [15:0] code_word, [19:16] key_index, [23:20] zero
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [23:0]                        m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [irc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [irc_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CntW = $clog2(CODE_BITS + 1);

  logic [CFG_W-1:0] sync_min_q, sync_max_q, one_min_q, one_max_q;
  logic [CFG_W-1:0] zero_floor_q, five_code_q;

  logic             in_vld_q;
  logic [GAP_W-1:0] gap_q;

  logic                 armed_q, armed_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CODE_BITS-1:0] shift_q, shift_d, shift_nxt;

  logic                  out_vld_q;
  logic [OUT_CODE_W-1:0] code_q;
  logic [KEY_W-1:0]      key_q;

  logic advance, one_hit, zero_hit, sync_hit, bit_add, done;
  logic [31:0] word_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_min_q   <= SYNC_MIN_RST;
      sync_max_q   <= SYNC_MAX_RST;
      one_min_q    <= ONE_MIN_RST;
      one_max_q    <= ONE_MAX_RST;
      zero_floor_q <= ZERO_FLOOR_RST;
      five_code_q  <= FIVE_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_MIN:   sync_min_q   <= cfg_data_i;
        CFG_SYNC_MAX:   sync_max_q   <= cfg_data_i;
        CFG_ONE_MIN:    one_min_q    <= cfg_data_i;
        CFG_ONE_MAX:    one_max_q    <= cfg_data_i;
        CFG_ZERO_FLOOR: zero_floor_q <= cfg_data_i;
        CFG_FIVE_CODE:  five_code_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the decode stage moves unless a completing gap would land on a full, stalled output register
  assign advance       = in_vld_q && (!done || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      gap_q <= s_axis_tdata;
    end
  end

  always_comb begin
    one_hit   = (gap_q >= one_min_q) && (gap_q <= one_max_q);
    zero_hit  = (gap_q < one_min_q) && (gap_q > zero_floor_q);
    sync_hit  = (gap_q >= sync_min_q) && (gap_q <= sync_max_q);
    bit_add   = armed_q && (one_hit || zero_hit);
    done      = bit_add && (cnt_q == CntW'(CODE_BITS - 1));
    shift_nxt = {shift_q[CODE_BITS-2:0], one_hit};
    word_ext  = 32'(shift_nxt);

    armed_d = armed_q || sync_hit;
    cnt_d   = bit_add ? cnt_q + CntW'(1) : cnt_q;
    shift_d = bit_add ? shift_nxt : shift_q;
    if (done) begin
      armed_d = 1'b0;
      cnt_d   = '0;
      shift_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      cnt_q   <= '0;
      shift_q <= '0;
    end else if (advance) begin
      armed_q <= armed_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && done) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && done) begin
      code_q <= word_ext[OUT_CODE_W-1:0];
      key_q  <= key_for(word_ext, five_code_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, key_q, code_q};

endmodule

`default_nettype wire

[hw/rtl/irc_checker.sv]
`default_nettype none

module irc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [15:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  import irc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // key index stays within the defined codes
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[19:16] <= KEY_NONE)
    else $error("key index out of range");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:20] == 4'd0)
    else $error("padding bits not zero");

  // with the result register empty the input side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind ir_remote_code_decoder_top irc_checker u_irc_checker (.*);

`default_nettype wire
